FILE: rtl/mck_pkg.sv
// Morse keyer package: types, code table ROM contents and lamp constants.
// Used by every module of the keyer; no dependencies.
`default_nettype none
package mck_pkg;

  localparam int          ERROR_LAMP_COUNT = 4;
  localparam int          UNIT_W           = 12;
  localparam int          DUR_W            = 15;
  localparam int          LAMP_W           = 4;
  localparam int          SYM_COUNT        = 36;
  localparam logic [11:0] UNIT_RESET       = 12'd100;

  localparam logic [LAMP_W-1:0] LAMP_MASK =
    (ERROR_LAMP_COUNT >= LAMP_W) ? {LAMP_W{1'b1}} :
    LAMP_W'((1 << ERROR_LAMP_COUNT) - 1);

  typedef enum logic [1:0] {
    CLS_MORSE,
    CLS_SPACE,
    CLS_ERROR,
    CLS_NONE
  } cls_t;

  typedef struct packed {
    logic [2:0] len;
    logic [4:0] bits;
  } sym_t;

  typedef struct packed {
    cls_t cls;
    sym_t sym;
  } lut_t;

  typedef struct packed {
    logic active;
    logic on_last;
  } seq_stat_t;

  // {len[2:0], bits[4:0]}, first element at bit 4, set bit is a dash. A..Z, 0..9.
  localparam logic [7:0] CODE_TAB [SYM_COUNT] = '{
    8'h48, 8'h90, 8'h94, 8'h70, 8'h20, 8'h84, 8'h78, 8'h80, 8'h40,
    8'h8E, 8'h74, 8'h88, 8'h58, 8'h50, 8'h7C, 8'h8C, 8'h9A, 8'h68,
    8'h60, 8'h30, 8'h64, 8'h82, 8'h6C, 8'h92, 8'h96, 8'h98,
    8'hBF, 8'hAF, 8'hA7, 8'hA3, 8'hA1, 8'hA0, 8'hB0, 8'hB8, 8'hBC, 8'hBE
  };

  localparam logic [7:0] CH_LA  = 8'h61;
  localparam logic [7:0] CH_LZ  = 8'h7A;
  localparam logic [7:0] CH_UA  = 8'h41;
  localparam logic [7:0] CH_UZ  = 8'h5A;
  localparam logic [7:0] CH_D0  = 8'h30;
  localparam logic [7:0] CH_D9  = 8'h39;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [5:0] DIGIT_BASE = 6'd26;

endpackage
`default_nettype wire

FILE: rtl/morse_character_keyer.sv
// Morse character keyer top level: unit time register, code ROM, sequencer.
// Depends on mck_pkg, mck_rom, mck_seq.
//
// A byte is taken when start is high and busy is low. In the cycle after, the code
// ROM word is ready and the sequencer loads it; segments then leave on out_*
// one per cycle, each marked by out_valid for a single cycle, with out_last on
// the final one. The receiver has no stall: it must take every strobed word.
// A character of n elements gives 2n+1 segments, a space one, an error six, CR
// and LF none. busy drops while the final segment is being formed, so the next
// byte's ROM read overlaps it and a character costs its segments plus the ROM read;
// the sequencer, at one segment per cycle, sets the pace. The first segment
// passes the ROM, sequencer state and output registers before it is driven.
// cfg_we writes the unit length in ms (reset 100 ms) and should only be used
// while the block is idle.
`default_nettype none
module morse_character_keyer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [mck_pkg::UNIT_W-1:0]    cfg_wdata,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [7:0]                    in_char_code,
  output logic                               out_valid,
  output logic                               out_signal_on,
  output logic [mck_pkg::LAMP_W-1:0]         out_error_lamps,
  output logic [mck_pkg::DUR_W-1:0]          out_duration_ms,
  output logic                               out_last
);
  import mck_pkg::*;

  logic [UNIT_W-1:0] unit_r;
  logic              accept;
  logic              rom_valid;
  lut_t              rom_data;
  seq_stat_t         stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r <= UNIT_RESET;
    end else if (cfg_we) begin
      unit_r <= cfg_wdata;
    end
  end

  assign busy   = rom_valid | (stat.active & ~stat.on_last);
  assign accept = start & ~busy;

  mck_rom u_rom (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .char_code (in_char_code),
    .rd_data   (rom_data),
    .rd_valid  (rom_valid)
  );

  mck_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (rom_valid),
    .lut             (rom_data),
    .unit_len        (unit_r),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_signal_on   (out_signal_on),
    .out_error_lamps (out_error_lamps),
    .out_duration_ms (out_duration_ms),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire

FILE: rtl/mck_rom.sv
// Character classifier and registered Morse code table ROM.
// Depends on mck_pkg.
`default_nettype none
module mck_rom (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          rd_en,
  input  wire logic [7:0]    char_code,
  output mck_pkg::lut_t      rd_data,
  output logic               rd_valid
);
  import mck_pkg::*;

  cls_t        cls;
  logic [5:0]  idx;
  logic [7:0]  diff;
  logic        rd_valid_r;
  lut_t        rd_data_r;

  always_comb begin
    diff = 8'd0;
    cls  = CLS_ERROR;
    idx  = 6'd0;
    priority if (char_code >= CH_LA && char_code <= CH_LZ) begin
      cls  = CLS_MORSE;
      diff = char_code - CH_LA;
      idx  = diff[5:0];
    end else if (char_code >= CH_UA && char_code <= CH_UZ) begin
      cls  = CLS_MORSE;
      diff = char_code - CH_UA;
      idx  = diff[5:0];
    end else if (char_code >= CH_D0 && char_code <= CH_D9) begin
      cls  = CLS_MORSE;
      diff = char_code - CH_D0;
      idx  = diff[5:0] + DIGIT_BASE;
    end else if (char_code == CH_SP) begin
      cls  = CLS_SPACE;
    end else if (char_code == CH_LF || char_code == CH_CR) begin
      cls  = CLS_NONE;
    end else begin
      cls  = CLS_ERROR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r.cls <= cls;
      rd_data_r.sym <= sym_t'(CODE_TAB[idx]);
    end
  end

  assign rd_data  = rd_data_r;
  assign rd_valid = rd_valid_r;

endmodule
`default_nettype wire

FILE: rtl/mck_seq.sv
// Segment sequencer: walks one word's segments, one per cycle, into output regs.
// Depends on mck_pkg; fed by mck_rom.
`default_nettype none
module mck_seq (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          load,
  input  wire mck_pkg::lut_t                 lut,
  input  wire logic [mck_pkg::UNIT_W-1:0]    unit_len,
  output mck_pkg::seq_stat_t                 stat,
  output logic                               out_valid,
  output logic                               out_signal_on,
  output logic [mck_pkg::LAMP_W-1:0]         out_error_lamps,
  output logic [mck_pkg::DUR_W-1:0]          out_duration_ms,
  output logic                               out_last
);
  import mck_pkg::*;

  logic              active_r, active_nxt;
  cls_t              kind_r, kind_nxt;
  logic [3:0]        seg_r, seg_nxt;
  logic [3:0]        seg_last_r, seg_last_nxt;
  logic [4:0]        bits_r, bits_nxt;

  logic              is_last;
  logic              sig;
  logic [LAMP_W-1:0] lamps;
  logic [2:0]        mult;

  logic              valid_r;
  logic              sig_r;
  logic [LAMP_W-1:0] lamps_r;
  logic [DUR_W-1:0]  dur_r;
  logic              last_r;

  assign is_last = (seg_r == seg_last_r);

  always_comb begin
    sig   = 1'b0;
    lamps = '0;
    mult  = 3'd1;
    unique case (kind_r)
      CLS_MORSE: begin
        if (is_last) begin
          mult = 3'd2;
        end else if (!seg_r[0]) begin
          sig  = 1'b1;
          mult = bits_r[4] ? 3'd3 : 3'd1;
        end
      end
      CLS_SPACE: begin
        mult = 3'd4;
      end
      CLS_ERROR: begin
        mult = 3'd5;
        if (!seg_r[0]) begin
          lamps = LAMP_MASK;
        end
      end
      CLS_NONE: begin
        mult = 3'd1;
      end
      default: begin
        mult = 3'd1;
      end
    endcase
  end

  always_comb begin
    active_nxt   = active_r;
    kind_nxt     = kind_r;
    seg_nxt      = seg_r;
    seg_last_nxt = seg_last_r;
    bits_nxt     = bits_r;
    if (load) begin
      active_nxt = (lut.cls != CLS_NONE);
      kind_nxt   = lut.cls;
      seg_nxt    = 4'd0;
      bits_nxt   = lut.sym.bits;
      unique case (lut.cls)
        CLS_MORSE: seg_last_nxt = {lut.sym.len, 1'b0};
        CLS_ERROR: seg_last_nxt = 4'd5;
        CLS_SPACE: seg_last_nxt = 4'd0;
        CLS_NONE:  seg_last_nxt = 4'd0;
        default:   seg_last_nxt = 4'd0;
      endcase
    end else if (active_r) begin
      if (is_last) begin
        active_nxt = 1'b0;
      end else begin
        seg_nxt = seg_r + 4'd1;
      end
      if (!seg_r[0]) begin
        bits_nxt = {bits_r[3:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      active_r <= active_nxt;
      valid_r  <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    seg_r      <= seg_nxt;
    seg_last_r <= seg_last_nxt;
    bits_r     <= bits_nxt;
    sig_r      <= sig;
    lamps_r    <= lamps;
    dur_r      <= DUR_W'(unit_len) * DUR_W'(mult);
    last_r     <= is_last;
  end

  assign stat = {active_r, active_r & is_last};

  assign out_valid       = valid_r;
  assign out_signal_on   = sig_r;
  assign out_error_lamps = lamps_r;
  assign out_duration_ms = dur_r;
  assign out_last        = last_r;

endmodule
`default_nettype wire

FILE: tb/sv/morse_character_keyer_tb.sv
// Self-checking bench for morse_character_keyer: directed characters, then random
// words over several unit time settings, every segment checked against a local model or typed table.
// Depends on mck_pkg and the keyer RTL.
module morse_character_keyer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mck_pkg::*;

  localparam int          CLK_HALF        = 6;
  localparam int          RESET_CYCLES    = 12;
  localparam int          SETTLE_CYCLES   = 16;
  localparam int          CYCLE_LIMIT     = 200000;
  localparam int          N_DIR           = 25;
  localparam int          N_TYPED         = 13;
  localparam int          N_PHASES        = 6;
  localparam int          ITEMS_PER_PHASE = 50;
  localparam logic [11:0] RESET_UNIT_MS   = 12'd100;

  typedef struct packed {
    logic              sig;
    logic [LAMP_W-1:0] lamps;
    logic [DUR_W-1:0]  dur;
    logic              last;
  } seg_t;

  typedef struct {
    logic [7:0] code;
    bit         typed;
    int         n_typed;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [UNIT_W-1:0] cfg_wdata = '0;
  logic              start = 1'b0;
  logic [7:0]        in_char_code = '0;
  logic              busy;
  logic              out_valid;
  logic              out_signal_on;
  logic [LAMP_W-1:0] out_error_lamps;
  logic [DUR_W-1:0]  out_duration_ms;
  logic              out_last;

  seg_t              exp_segs [$];
  seg_t              want;
  logic [11:0]       unit_ms = RESET_UNIT_MS;
  int                words_sent = 0;
  int                segs_checked = 0;
  int                errors = 0;
  int                cycle_cnt = 0;

  // A..Z then 0..9
  string morse_tab [36] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
    "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
    "..-", "...-", ".--", "-..-", "-.--", "--..",
    "-----", ".----", "..---", "...--", "....-",
    ".....", "-....", "--...", "---..", "----."
  };

  // typed rows assume the reset unit of 100 ms
  dir_row_t dir_rows [N_DIR] = '{
    '{8'h45, 1'b1, 3}, '{8'h54, 1'b1, 3}, '{8'h20, 1'b1, 1}, '{8'h00, 1'b1, 6},
    '{8'h0D, 1'b1, 0}, '{8'h0A, 1'b1, 0},
    '{8'h41, 1'b0, 0}, '{8'h5A, 1'b0, 0}, '{8'h61, 1'b0, 0}, '{8'h7A, 1'b0, 0},
    '{8'h30, 1'b0, 0}, '{8'h39, 1'b0, 0}, '{8'h35, 1'b0, 0}, '{8'h4A, 1'b0, 0},
    '{8'h71, 1'b0, 0}, '{8'h40, 1'b0, 0}, '{8'h5B, 1'b0, 0}, '{8'h60, 1'b0, 0},
    '{8'h7B, 1'b0, 0}, '{8'h2F, 1'b0, 0}, '{8'h3A, 1'b0, 0}, '{8'h7F, 1'b0, 0},
    '{8'h80, 1'b0, 0}, '{8'hFF, 1'b0, 0}, '{8'h1F, 1'b0, 0}
  };

  seg_t typed_segs [N_TYPED] = '{
    '{1'b1, 4'h0, 15'd100, 1'b0}, '{1'b0, 4'h0, 15'd100, 1'b0},
    '{1'b0, 4'h0, 15'd200, 1'b1},
    '{1'b1, 4'h0, 15'd300, 1'b0}, '{1'b0, 4'h0, 15'd100, 1'b0},
    '{1'b0, 4'h0, 15'd200, 1'b1},
    '{1'b0, 4'h0, 15'd400, 1'b1},
    '{1'b0, 4'hF, 15'd500, 1'b0}, '{1'b0, 4'h0, 15'd500, 1'b0},
    '{1'b0, 4'hF, 15'd500, 1'b0}, '{1'b0, 4'h0, 15'd500, 1'b0},
    '{1'b0, 4'hF, 15'd500, 1'b0}, '{1'b0, 4'h0, 15'd500, 1'b1}
  };

  logic [11:0] phase_unit [N_PHASES] = '{12'd1, 12'd4095, 12'd0, 12'hAAA, 12'h555, 12'd0};
  int          phase_idle [N_PHASES] = '{0, 54, 0, 37, 54, 37};

  morse_character_keyer u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .start           (start),
    .busy            (busy),
    .in_char_code    (in_char_code),
    .out_valid       (out_valid),
    .out_signal_on   (out_signal_on),
    .out_error_lamps (out_error_lamps),
    .out_duration_ms (out_duration_ms),
    .out_last        (out_last)
  );

  always #CLK_HALF clk = ~clk;

  function automatic void push_seg(input logic sig, input logic [LAMP_W-1:0] lamps,
                                   input int units, input logic last);
    seg_t s;
    s.sig   = sig;
    s.lamps = lamps;
    s.dur   = DUR_W'(int'(unit_ms) * units);
    s.last  = last;
    exp_segs.push_back(s);
  endfunction

  // Expected segments for one received byte.
  function automatic void expand_char(input logic [7:0] code);
    int                idx;
    string             pat;
    logic [LAMP_W-1:0] lamps_on;
    idx = -1;
    lamps_on = (ERROR_LAMP_COUNT >= LAMP_W) ? {LAMP_W{1'b1}}
                                            : LAMP_W'((1 << ERROR_LAMP_COUNT) - 1);
    if (code >= "a" && code <= "z")
      idx = code - "a";
    else if (code >= "A" && code <= "Z")
      idx = code - "A";
    else if (code >= "0" && code <= "9")
      idx = code - "0" + 26;
    if (idx >= 0) begin
      pat = morse_tab[idx];
      for (int i = 0; i < pat.len(); i++) begin
        push_seg(1'b1, '0, (pat[i] == "-") ? 3 : 1, 1'b0);
        push_seg(1'b0, '0, 1, 1'b0);
      end
      push_seg(1'b0, '0, 2, 1'b1);
    end else if (code == " ") begin
      push_seg(1'b0, '0, 4, 1'b1);
    end else if (code != 8'h0A && code != 8'h0D) begin
      for (int r = 0; r < 3; r++) begin
        push_seg(1'b0, lamps_on, 5, 1'b0);
        push_seg(1'b0, '0, 5, r == 2);
      end
    end
  endfunction

  task automatic accept_word(input logic [7:0] code);
    start <= 1'b1;
    in_char_code <= code;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    words_sent++;
  endtask

  // Drop start, let every expected segment arrive, then allow for CR/LF still in flight.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (exp_segs.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (exp_segs.size() == 0) begin
        errors++;
        $display("%0t: unexpected segment sig=%0b lamps=%h dur=%0d last=%0b", $time,
                 out_signal_on, out_error_lamps, out_duration_ms, out_last);
      end else begin
        want = exp_segs.pop_front();
        segs_checked++;
        if (out_signal_on !== want.sig || out_error_lamps !== want.lamps ||
            out_duration_ms !== want.dur || out_last !== want.last) begin
          errors++;
          $display("%0t: segment mismatch exp sig=%0b lamps=%h dur=%0d last=%0b", $time,
                   want.sig, want.lamps, want.dur, want.last);
          $display("%0t:                  act sig=%0b lamps=%h dur=%0d last=%0b", $time,
                   out_signal_on, out_error_lamps, out_duration_ms, out_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d segments outstanding", cycle_cnt,
               exp_segs.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int          ti;
    int          r;
    int          p;
    logic [7:0]  code;
    logic [11:0] unit_val;
    ti = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      accept_word(dir_rows[i].code);
      if (dir_rows[i].typed) begin
        repeat (dir_rows[i].n_typed) begin
          exp_segs.push_back(typed_segs[ti]);
          ti++;
        end
      end else begin
        expand_char(dir_rows[i].code);
      end
    end

    for (p = 0; p < N_PHASES; p++) begin
      wait_drained();
      unit_val = (p == N_PHASES - 1) ? 12'($urandom_range(1, 4095)) : phase_unit[p];
      cfg_we <= 1'b1;
      cfg_wdata <= unit_val;
      @(posedge clk);
      cfg_we <= 1'b0;
      unit_ms = unit_val;
      repeat (ITEMS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        if (r < 22)
          code = 8'h41 + 8'($urandom_range(0, 25));
        else if (r < 44)
          code = 8'h61 + 8'($urandom_range(0, 25));
        else if (r < 58)
          code = 8'h30 + 8'($urandom_range(0, 9));
        else if (r < 66)
          code = 8'h20;
        else if (r < 70)
          code = $urandom_range(0, 1) ? 8'h0A : 8'h0D;
        else
          code = 8'($urandom_range(0, 255));
        accept_word(code);
        expand_char(code);
        if ($urandom_range(0, 99) < phase_idle[p]) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 16)) @(posedge clk);
        end
      end
    end

    wait_drained();
    $display("ran %0d words and checked %0d segments", words_sent, segs_checked);
    $display("unit times: reset 100, 1, 4095, 0, 0xaaa, 0x555 and a random one (%0d ms)",
             unit_ms);
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: files.f
rtl/mck_pkg.sv
rtl/mck_rom.sv
rtl/mck_seq.sv
rtl/morse_character_keyer.sv
tb/sv/morse_character_keyer_tb.sv
